// ----- hw/rtl/fba_pkg.sv -----
// Shared types and constants for the frame bump allocator.
`default_nettype none
package fba_pkg;

	localparam int REG_W        = 13;
	localparam int HEADER_BYTES = 8;

	typedef logic [1:0]       mode_t;
	typedef logic [1:0]       err_t;
	typedef logic [REG_W-1:0] reg13_t;

	localparam mode_t MODE_ALLOC = 2'd0;
	localparam mode_t MODE_FREE  = 2'd1;
	localparam mode_t MODE_BEGIN = 2'd2;

	localparam err_t ERR_NONE        = 2'd0;
	localparam err_t ERR_EMPTY_POOL  = 2'd1;
	localparam err_t ERR_BLOCKS_LIVE = 2'd2;

	localparam logic REG_MAX_RESERVE     = 1'b0;
	localparam logic REG_INITIAL_RESERVE = 1'b1;

	localparam reg13_t COUNT_MAX       = 13'h1FFF;
	localparam reg13_t MAX_RESERVE_RST = 13'd4096;

endpackage
`default_nettype wire

// ----- hw/rtl/fba_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module fba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/frame_bump_allocator.sv -----
// Frame bump allocator: sequencer, counters, header store and result register.
//
//  channel   ports                                  transaction
//  command   start, busy, mode, alloc_bytes, address start & !busy
//  result    done, data_offset, fallback, error_code one cycle on done
//  config    cfg_wr_en, cfg_index, cfg_wdata         cfg_wr_en
//
// A command reads the header store as it is taken, then updates state in the
// cycle in which busy is high. The result appears the cycle after that,
// while the next command may already be taken. Reset clears all counters and
// loads the reserve with its default; the header store is not cleared.
// The receiver cannot stall the result.
`default_nettype none
module frame_bump_allocator #(
	parameter int POOL_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] alloc_bytes,
	input  wire logic [31:0] address,
	output      logic        done,
	output      logic [11:0] data_offset,
	output      logic        fallback,
	output      logic [1:0]  error_code,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_wdata
);

	localparam int DEPTH     = (POOL_BYTES > 8192) ? 8192 : POOL_BYTES;
	localparam int AW        = $clog2(DEPTH);
	localparam int CAP_INT   = (POOL_BYTES > 8191) ? 8191 : POOL_BYTES;
	localparam int RINIT_INT = (POOL_BYTES > 1024) ? 1024 : POOL_BYTES;
	localparam fba_pkg::reg13_t RES_CAP  = fba_pkg::reg13_t'(CAP_INT);
	localparam fba_pkg::reg13_t RES_INIT = fba_pkg::reg13_t'(RINIT_INT);
	localparam fba_pkg::reg13_t HB13     = fba_pkg::reg13_t'(fba_pkg::HEADER_BYTES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic accept;

	fba_pkg::mode_t  mode_s1;
	logic [15:0]     bytes_s1;
	logic [31:0]     addr_s1;

	fba_pkg::reg13_t max_q;
	fba_pkg::reg13_t res_q;
	fba_pkg::reg13_t fill_q;
	fba_pkg::reg13_t cnt_q;
	logic [31:0]     spill_q;
	logic [31:0]     hw_q;

	fba_pkg::reg13_t fill_d;
	fba_pkg::reg13_t cnt_d;
	fba_pkg::reg13_t res_d;
	logic [31:0]     spill_d;
	logic [31:0]     hw_d;
	logic [11:0]     data_d;
	logic            fb_d;
	fba_pkg::err_t   err_d;
	logic            hdr_we;

	logic [15:0]     hdr_rdata;
	logic [AW-1:0]   hdr_raddr;

	logic [16:0]     end_w;
	logic [13:0]     pay_w;
	logic            fits;
	logic [32:0]     spill_sum;
	logic [31:0]     spill_sat;
	logic [32:0]     used_sum;
	logic [31:0]     used_sat;
	logic            in_pool;
	fba_pkg::reg13_t cnt_dec;
	logic [15:0]     sz;
	logic            topmost;
	logic [16:0]     blk;
	fba_pkg::reg13_t rolled;
	logic [31:0]     r0;
	fba_pkg::reg13_t r1;

	assign busy      = (state_q == ST_EXEC);
	assign accept    = start && !busy;
	assign hdr_raddr = AW'(address - 32'(fba_pkg::HEADER_BYTES));

	fba_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_hdr_ram (
		.clk  (clk),
		.we   (hdr_we),
		.waddr(fill_q[AW-1:0]),
		.wdata(bytes_s1),
		.re   (accept && (mode == fba_pkg::MODE_FREE)),
		.raddr(hdr_raddr),
		.rdata(hdr_rdata)
	);

	always_comb begin
		end_w     = 17'(fill_q) + 17'(bytes_s1) + 17'(HB13);
		pay_w     = 14'(fill_q) + 14'(HB13);
		fits      = (end_w <= 17'(res_q)) && (pay_w < 14'(res_q)) &&
			(cnt_q != fba_pkg::COUNT_MAX);
		spill_sum = {1'b0, spill_q} + 33'(bytes_s1);
		spill_sat = spill_sum[32] ? 32'hFFFF_FFFF : spill_sum[31:0];
		used_sum  = {1'b0, spill_q} + 33'(fill_q);
		used_sat  = used_sum[32] ? 32'hFFFF_FFFF : used_sum[31:0];
		in_pool   = addr_s1 < 32'(res_q);
		cnt_dec   = cnt_q - 13'd1;
		sz        = (addr_s1 >= 32'(fba_pkg::HEADER_BYTES)) ? hdr_rdata : 16'd0;
		topmost   = (33'(addr_s1) + 33'(sz)) >= 33'(fill_q);
		blk       = 17'(sz) + 17'(HB13);
		rolled    = (blk > 17'(fill_q)) ? 13'd0 : (fill_q - blk[12:0]);
		r0        = (hw_q > 32'(res_q)) ? hw_q : 32'(res_q);
		r1        = (r0 > 32'(max_q)) ? max_q : r0[12:0];

		fill_d  = fill_q;
		cnt_d   = cnt_q;
		res_d   = res_q;
		spill_d = spill_q;
		hw_d    = hw_q;
		data_d  = 12'd0;
		fb_d    = 1'b0;
		err_d   = fba_pkg::ERR_NONE;
		hdr_we  = 1'b0;

		case (mode_s1)
			fba_pkg::MODE_ALLOC: begin
				if (fits) begin
					hdr_we = busy;
					cnt_d  = cnt_q + 13'd1;
					fill_d = end_w[12:0];
					data_d = pay_w[11:0];
				end else begin
					spill_d = spill_sat;
					fb_d    = 1'b1;
				end
			end
			fba_pkg::MODE_FREE: begin
				if (used_sat > hw_q) begin
					hw_d = used_sat;
				end
				if (!in_pool) begin
					fb_d = 1'b1;
				end else if (cnt_q == 13'd0) begin
					err_d = fba_pkg::ERR_EMPTY_POOL;
				end else begin
					cnt_d = cnt_dec;
					if (cnt_dec == 13'd0) begin
						fill_d = 13'd0;
					end else if (topmost) begin
						fill_d = rolled;
					end
				end
			end
			fba_pkg::MODE_BEGIN: begin
				if (cnt_q != 13'd0) begin
					err_d = fba_pkg::ERR_BLOCKS_LIVE;
				end else begin
					res_d   = (r1 > RES_CAP) ? RES_CAP : r1;
					hw_d    = 32'd0;
					fill_d  = 13'd0;
					spill_d = 32'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			bytes_s1 <= alloc_bytes;
			addr_s1  <= address;
		end
		if (busy) begin
			data_offset <= data_d;
			fallback    <= fb_d;
			error_code  <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
			max_q   <= fba_pkg::MAX_RESERVE_RST;
			res_q   <= RES_INIT;
			fill_q  <= 13'd0;
			cnt_q   <= 13'd0;
			spill_q <= 32'd0;
			hw_q    <= 32'd0;
		end else begin
			done <= busy;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					fill_q  <= fill_d;
					cnt_q   <= cnt_d;
					res_q   <= res_d;
					spill_q <= spill_d;
					hw_q    <= hw_d;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_wr_en) begin
				if (cfg_index == fba_pkg::REG_MAX_RESERVE) begin
					max_q <= cfg_wdata;
				end else begin
					res_q <= (cfg_wdata > RES_CAP) ? RES_CAP : cfg_wdata;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- sim/frame_bump_allocator_test.sv -----
// Testbench for the frame bump allocator: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module frame_bump_allocator_test;

	localparam int POOL_BYTES = 4096;
	localparam int HDR_AW = $clog2(POOL_BYTES);
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_LIMIT = 100;
	localparam fba_pkg::mode_t MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [11:0]   offset;
		logic          spilled;
		fba_pkg::err_t err;
	} outcome_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	fba_pkg::mode_t  mode;
	logic [15:0]     alloc_bytes;
	logic [31:0]     address;
	logic            done;
	logic [11:0]     data_offset;
	logic            fallback;
	fba_pkg::err_t   error_code;
	logic            cfg_wr_en;
	logic            cfg_index;
	fba_pkg::reg13_t cfg_wdata;

	frame_bump_allocator #(
		.POOL_BYTES(POOL_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.alloc_bytes(alloc_bytes),
		.address(address),
		.done(done),
		.data_offset(data_offset),
		.fallback(fallback),
		.error_code(error_code),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// allocator state as the testbench sees it
	fba_pkg::reg13_t max_res = 13'd4096;
	fba_pkg::reg13_t reserve = 13'd1024;
	fba_pkg::reg13_t fill = '0;
	fba_pkg::reg13_t blocks = '0;
	logic [31:0]     spill = '0;
	logic [31:0]     high_water = '0;
	logic [15:0]     hdr_size [0:POOL_BYTES-1];
	bit              hdr_set [0:POOL_BYTES-1];

	outcome_t    outcomes_due [$];
	outcome_t    last_outcome;
	outcome_t    want;
	logic [31:0] live [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          cmd_count = 0;
	int          burst_left = 0;
	bit          idling_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic fba_pkg::reg13_t pool_cap(logic [31:0] v);
		return (v > POOL_BYTES) ? fba_pkg::reg13_t'(POOL_BYTES) : v[12:0];
	endfunction

	function automatic outcome_t allocator_outcome(fba_pkg::mode_t op, logic [15:0] bytes,
			logic [31:0] addr);
		outcome_t    o;
		logic [31:0] blk_end, pay, used, sz, span, pick;
		o = '0;
		case (op)
		fba_pkg::MODE_ALLOC: begin
			blk_end = 32'(fill) + 32'(bytes) + fba_pkg::HEADER_BYTES;
			pay = 32'(fill) + fba_pkg::HEADER_BYTES;
			if (blk_end <= 32'(reserve) && pay < 32'(reserve) &&
					blocks < fba_pkg::COUNT_MAX) begin
				hdr_size[fill[HDR_AW-1:0]] = bytes;
				hdr_set[fill[HDR_AW-1:0]] = 1'b1;
				blocks = blocks + 1'b1;
				fill = blk_end[12:0];
				o.offset = pay[11:0];
			end else begin
				spill = sat_sum(spill, 32'(bytes));
				o.spilled = 1'b1;
			end
		end
		fba_pkg::MODE_FREE: begin
			used = sat_sum(32'(fill), spill);
			if (used > high_water)
				high_water = used;
			if (addr < 32'(reserve)) begin
				if (blocks == '0) begin
					o.err = fba_pkg::ERR_EMPTY_POOL;
				end else begin
					blocks = blocks - 1'b1;
					if (blocks == '0) begin
						fill = '0;
					end else begin
						sz = '0;
						if (addr >= fba_pkg::HEADER_BYTES)
							sz = 32'(hdr_size[HDR_AW'(addr - fba_pkg::HEADER_BYTES)]);
						if (addr + sz >= 32'(fill)) begin
							span = sz + fba_pkg::HEADER_BYTES;
							fill = (span > 32'(fill)) ? '0
								: fba_pkg::reg13_t'(32'(fill) - span);
						end
					end
				end
			end else begin
				o.spilled = 1'b1;
			end
		end
		fba_pkg::MODE_BEGIN: begin
			if (blocks != '0) begin
				o.err = fba_pkg::ERR_BLOCKS_LIVE;
			end else begin
				pick = (32'(reserve) > high_water) ? 32'(reserve) : high_water;
				if (pick > 32'(max_res))
					pick = 32'(max_res);
				reserve = pool_cap(pick);
				high_water = '0;
				fill = '0;
				spill = '0;
			end
		end
		default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
			end else begin
				want = outcomes_due.pop_front();
				if (data_offset !== want.offset)
					report_mismatch($sformatf("data_offset %0d, expected %0d",
						data_offset, want.offset));
				if (fallback !== want.spilled)
					report_mismatch($sformatf("fallback %b, expected %b",
						fallback, want.spilled));
				if (error_code !== want.err)
					report_mismatch($sformatf("error_code %0d, expected %0d",
						error_code, want.err));
			end
		end
	end

	// one command transaction, with bursty gaps ahead of it
	task automatic issue(fba_pkg::mode_t op, logic [15:0] bytes, logic [31:0] addr);
		int gap;
		if (idling_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 7);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		start <= 1'b1;
		mode <= op;
		alloc_bytes <= bytes;
		address <= addr;
		do @(posedge clk); while (busy);
		last_outcome = allocator_outcome(op, bytes, addr);
		outcomes_due.push_back(last_outcome);
		if (op == fba_pkg::MODE_ALLOC && !last_outcome.spilled)
			live.push_back(32'(last_outcome.offset));
		if (blocks == '0)
			live.delete();
		if (op != MODE_UNUSED)
			cmd_count++;
	endtask

	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		while (outcomes_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, fba_pkg::reg13_t val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == fba_pkg::REG_MAX_RESERVE) begin
			max_res = val;
		end else begin
			reserve = pool_cap(32'(val));
		end
		@(posedge clk);
	endtask

	// never point a free at a header slot that was never written
	function automatic logic [31:0] safe_free_addr(logic [31:0] a);
		if (a < 32'(reserve) && a >= fba_pkg::HEADER_BYTES &&
				!hdr_set[HDR_AW'(a - fba_pkg::HEADER_BYTES)])
			return 32'(reserve) + $urandom_range(0, 255);
		return a;
	endfunction

	task automatic test_edge_cases();
		issue(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
		issue(fba_pkg::MODE_FREE, '0, '0);
		issue(fba_pkg::MODE_FREE, '0, 32'hFFFF_FFFF);
		issue(fba_pkg::MODE_ALLOC, '0, '0);
		issue(fba_pkg::MODE_ALLOC, 16'hFFFF, '0);
		issue(fba_pkg::MODE_ALLOC, 16'd1000, '0);
		issue(fba_pkg::MODE_ALLOC, '0, '0);
		issue(fba_pkg::MODE_BEGIN, '0, '0);
		issue(fba_pkg::MODE_FREE, '0, 32'd3);
		issue(fba_pkg::MODE_FREE, '0, 32'd16);
		issue(fba_pkg::MODE_BEGIN, '0, '0);
		// stale size in a freed block's header drives the rollback below zero
		issue(fba_pkg::MODE_ALLOC, '0, '0);
		issue(fba_pkg::MODE_ALLOC, '0, '0);
		issue(fba_pkg::MODE_ALLOC, 16'd3000, '0);
		issue(fba_pkg::MODE_FREE, '0, 32'd24);
		issue(fba_pkg::MODE_FREE, '0, 32'd24);
		issue(fba_pkg::MODE_FREE, '0, 32'd16);
		issue(fba_pkg::MODE_BEGIN, '0, '0);
	endtask

	task automatic test_register_limits();
		drain();
		cfg_write(fba_pkg::REG_INITIAL_RESERVE, 13'h1FFF);
		issue(fba_pkg::MODE_ALLOC, 16'd4088, '0);
		issue(fba_pkg::MODE_FREE, '0, 32'd8);
		drain();
		cfg_write(fba_pkg::REG_MAX_RESERVE, '0);
		issue(fba_pkg::MODE_BEGIN, '0, '0);
		issue(fba_pkg::MODE_ALLOC, '0, '0);
		issue(fba_pkg::MODE_FREE, '0, '0);
		drain();
		cfg_write(fba_pkg::REG_MAX_RESERVE, 13'h1FFF);
		issue(fba_pkg::MODE_ALLOC, 16'hFFFF, '0);
		issue(fba_pkg::MODE_FREE, '0, 32'hFFFF_FFFF);
		issue(fba_pkg::MODE_BEGIN, '0, '0);
	endtask

	task automatic test_spill_accumulation();
		drain();
		cfg_write(fba_pkg::REG_INITIAL_RESERVE, 13'd64);
		issue(fba_pkg::MODE_ALLOC, 16'd8, '0);
		idling_on = 1'b0;
		repeat (8) issue(fba_pkg::MODE_ALLOC, 16'hFFFF, $urandom);
		issue(fba_pkg::MODE_FREE, '0, 32'h8000_0000);
		issue(fba_pkg::MODE_FREE, '0, 32'd8);
		issue(fba_pkg::MODE_BEGIN, '0, '0);
		idling_on = 1'b1;
	endtask

	task automatic random_step();
		int          roll, sel;
		logic [15:0] size;
		logic [31:0] addr;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			case ($urandom_range(0, 3))
			0: issue(MODE_UNUSED, 16'($urandom), $urandom);
			1: begin
				addr = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4200);
				issue(fba_pkg::MODE_FREE, 16'($urandom), safe_free_addr(addr));
			end
			2: issue(fba_pkg::MODE_BEGIN, 16'($urandom), $urandom);
			default: issue(fba_pkg::MODE_ALLOC, 16'($urandom), $urandom);
			endcase
		end else if (blocks == '0 && roll < 25) begin
			issue(fba_pkg::MODE_BEGIN, 16'($urandom), $urandom);
		end else if (live.size() == 0 && blocks != '0 && reserve != '0) begin
			// orphaned blocks: release them through addresses below the header size
			sel = (reserve > fba_pkg::HEADER_BYTES) ? fba_pkg::HEADER_BYTES - 1
				: reserve - 1;
			issue(fba_pkg::MODE_FREE, 16'($urandom), $urandom_range(0, sel));
		end else if (live.size() != 0 && (roll < 60 || live.size() > 12)) begin
			sel = ($urandom_range(0, 3) != 0) ? live.size() - 1
				: $urandom_range(0, live.size() - 1);
			addr = live[sel];
			live.delete(sel);
			issue(fba_pkg::MODE_FREE, 16'($urandom), addr);
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 75)
				size = 16'($urandom_range(0, 40));
			else if (sel < 95)
				size = 16'($urandom_range(0, 700));
			else
				size = 16'($urandom);
			issue(fba_pkg::MODE_ALLOC, size, $urandom);
		end
	endtask

	task automatic test_random_frames();
		int              target;
		fba_pkg::reg13_t max_v, init_v;
		for (int p = 0; p < 8; p++) begin
			case (p)
			0: begin max_v = 13'd4096; init_v = 13'd1024; end
			1: begin max_v = 13'd4096; init_v = 13'd4096; end
			2: begin max_v = 13'd0;    init_v = 13'd4096; end
			3: begin max_v = 13'd4096; init_v = 13'd0;    end
			4: begin max_v = 13'd300;  init_v = 13'd200;  end
			5: begin max_v = 13'h1FFF; init_v = 13'h1FFF; end
			default: begin
				max_v = 13'($urandom_range(0, 4096));
				init_v = 13'($urandom_range(0, 4096));
			end
			endcase
			drain();
			cfg_write(fba_pkg::REG_MAX_RESERVE, max_v);
			cfg_write(fba_pkg::REG_INITIAL_RESERVE, init_v);
			idling_on = (p != 1);
			target = cmd_count + 125;
			while (cmd_count < target)
				random_step();
		end
		idling_on = 1'b1;
	endtask

	initial begin
		start <= 1'b0;
		mode <= fba_pkg::MODE_ALLOC;
		alloc_bytes <= '0;
		address <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= fba_pkg::REG_MAX_RESERVE;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_cases();
		test_register_limits();
		test_spill_accumulation();
		test_random_frames();
		drain();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
